FILE: hdl/dngr_pkg.sv
// ----------------------------------------------------------------------------
// dngr_pkg
// Shared types, constants and the digit glyph table of the decimal number
// glyph renderer.
// ----------------------------------------------------------------------------
package dngr_pkg;

  localparam int NUMBER_W  = 31;
  localparam int COORD_W   = 10;
  localparam int GLYPH_X_W = 11;
  localparam int BITS_W    = 20;
  localparam int DIGIT_W   = 4;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int GLYPH_WIDTH    = 4;
  localparam int GLYPH_HEIGHT   = 5;
  localparam int GLYPH_PITCH    = GLYPH_WIDTH + 1;

  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = NUMBER_W + 32;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic last;
  } sts_t;

  function automatic logic [BITS_W-1:0] glyph_rom(input logic [DIGIT_W-1:0] d);
    logic [BITS_W-1:0] g;
    case (d)
      4'd0:    g = 20'hF999F;
      4'd1:    g = 20'hF2232;
      4'd2:    g = 20'hF168F;
      4'd3:    g = 20'hF8E8F;
      4'd4:    g = 20'h44F64;
      4'd5:    g = 20'h7871F;
      4'd6:    g = 20'h6971E;
      4'd7:    g = 20'h1248F;
      4'd8:    g = 20'hF9F9F;
      4'd9:    g = 20'hF8F9F;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: hdl/dngr_number_if.sv
// ----------------------------------------------------------------------------
// dngr_number_if
// Input channel: number to draw and the text box origin.
// ----------------------------------------------------------------------------
interface dngr_number_if;
  logic                          valid;
  logic                          ready;
  logic [dngr_pkg::NUMBER_W-1:0] number_value;
  logic [dngr_pkg::COORD_W-1:0]  origin_x;
  logic [dngr_pkg::COORD_W-1:0]  origin_y;

  modport source (output valid, number_value, origin_x, origin_y, input ready);
  modport sink   (input valid, number_value, origin_x, origin_y, output ready);
endinterface

FILE: hdl/dngr_glyph_if.sv
// ----------------------------------------------------------------------------
// dngr_glyph_if
// Output channel: one glyph placement per decimal digit.
// ----------------------------------------------------------------------------
interface dngr_glyph_if;
  logic                           valid;
  logic                           ready;
  logic [dngr_pkg::GLYPH_X_W-1:0] glyph_x;
  logic [dngr_pkg::COORD_W-1:0]   glyph_y;
  logic [dngr_pkg::BITS_W-1:0]    glyph_bits;
  logic [dngr_pkg::DIGIT_W-1:0]   digit_value;
  logic                           last_digit;

  modport source (output valid, glyph_x, glyph_y, glyph_bits, digit_value, last_digit,
                  input ready);
  modport sink   (input valid, glyph_x, glyph_y, glyph_bits, digit_value, last_digit,
                  output ready);
endinterface

FILE: hdl/decimal_number_glyph_renderer.sv
// ----------------------------------------------------------------------------
// decimal_number_glyph_renderer
// Splits a number into decimal digits and emits one 4x5 glyph per digit.
//
// Channels: number (sink) takes number_value, origin_x, origin_y; glyph
// (source) gives glyph_x, glyph_y, glyph_bits, digit_value, last_digit.
// A transaction completes when valid and ready are both high at a clock edge.
// Digits come out least significant first; last_digit marks the most
// significant one, which sits at origin_x. Zero gives a single digit 0.
// Numbers with more than MAX_DIGITS digits keep the low MAX_DIGITS digits.
// Sequence: the number is loaded, then each digit takes one pass of the
// divide loop (reciprocal multiply, then quotient/remainder), and the
// glyphs are emitted only after all digits have been split. The first
// glyph is offered once the last divide step is done.
// One number is handled at a time; number.ready is high only when idle.
// When the receiver stalls, the current glyph is held unchanged.
// Synchronous reset returns the block to idle; pending glyphs are dropped.
// ----------------------------------------------------------------------------
module decimal_number_glyph_renderer #(
  parameter int MAX_DIGITS = dngr_pkg::MAX_DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  dngr_number_if.sink  number,
  dngr_glyph_if.source glyph
);

  dngr_pkg::cmd_t cmd;
  dngr_pkg::sts_t sts;

  dngr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (glyph.valid),
    .out_ready (glyph.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dngr_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .number_value (number.number_value),
    .origin_x     (number.origin_x),
    .origin_y     (number.origin_y),
    .glyph_x      (glyph.glyph_x),
    .glyph_y      (glyph.glyph_y),
    .glyph_bits   (glyph.glyph_bits),
    .digit_value  (glyph.digit_value),
    .last_digit   (glyph.last_digit)
  );

endmodule

FILE: hdl/dngr_dp.sv
// ----------------------------------------------------------------------------
// dngr_dp
// Datapath: divide-by-ten by reciprocal multiply, digit store, glyph
// position accumulator and glyph lookup.
// ----------------------------------------------------------------------------
module dngr_dp #(
  parameter int MAX_DIGITS = dngr_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dngr_pkg::cmd_t                 cmd,
  output dngr_pkg::sts_t                 sts,
  input  logic [dngr_pkg::NUMBER_W-1:0]  number_value,
  input  logic [dngr_pkg::COORD_W-1:0]   origin_x,
  input  logic [dngr_pkg::COORD_W-1:0]   origin_y,
  output logic [dngr_pkg::GLYPH_X_W-1:0] glyph_x,
  output logic [dngr_pkg::COORD_W-1:0]   glyph_y,
  output logic [dngr_pkg::BITS_W-1:0]    glyph_bits,
  output logic [dngr_pkg::DIGIT_W-1:0]   digit_value,
  output logic                           last_digit
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [dngr_pkg::NUMBER_W-1:0]  n;
  logic [dngr_pkg::QUOT_W-1:0]    q;
  logic [CNT_W-1:0]               cnt;
  logic [IDX_W-1:0]               k;
  logic [dngr_pkg::GLYPH_X_W-1:0] x;
  logic [dngr_pkg::COORD_W-1:0]   y;
  logic [dngr_pkg::DIGIT_W-1:0]   digs [MAX_DIGITS];

  logic [dngr_pkg::PROD_W-1:0]    prod;
  logic [dngr_pkg::NUMBER_W-1:0]  q_ext;
  logic [dngr_pkg::NUMBER_W-1:0]  q_times_ten;
  logic [dngr_pkg::NUMBER_W-1:0]  rem_full;
  logic [dngr_pkg::DIGIT_W-1:0]   rem;

  assign prod        = dngr_pkg::PROD_W'(n) * dngr_pkg::PROD_W'(dngr_pkg::RECIP_TEN);
  assign q_ext       = dngr_pkg::NUMBER_W'(q);
  assign q_times_ten = (q_ext << 3) + (q_ext << 1);
  assign rem_full    = n - q_times_ten;
  assign rem         = rem_full[dngr_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= number_value;
      x <= dngr_pkg::GLYPH_X_W'(origin_x);
      y <= origin_y;
    end else if (cmd.step) begin
      n <= q_ext;
      if (sts.more) begin
        x <= x + dngr_pkg::GLYPH_X_W'(dngr_pkg::GLYPH_PITCH);
      end
    end else if (cmd.advance) begin
      x <= x - dngr_pkg::GLYPH_X_W'(dngr_pkg::GLYPH_PITCH);
    end
    if (cmd.mul) begin
      q <= prod[dngr_pkg::PROD_W-1:dngr_pkg::RECIP_SHIFT];
    end
    if (cmd.step) begin
      digs[cnt[IDX_W-1:0]] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      k   <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
      k   <= '0;
    end else begin
      if (cmd.step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.advance) begin
        k <= k + IDX_W'(1);
      end
    end
  end

  assign sts.more = (q != '0) && (cnt < CNT_W'(MAX_DIGITS - 1));
  assign sts.last = (CNT_W'(k) == cnt - CNT_W'(1));

  assign glyph_x     = x;
  assign glyph_y     = y;
  assign digit_value = digs[k];
  assign glyph_bits  = dngr_pkg::glyph_rom(digs[k]);
  assign last_digit  = sts.last;

endmodule

FILE: hdl/dngr_ctrl.sv
// ----------------------------------------------------------------------------
// dngr_ctrl
// Controller: sequences load, divide steps and glyph emission.
// ----------------------------------------------------------------------------
module dngr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dngr_pkg::cmd_t cmd,
  input  dngr_pkg::sts_t sts
);

  dngr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dngr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      dngr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = dngr_pkg::S_MUL;
        end
      end
      dngr_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = dngr_pkg::S_DIV;
      end
      dngr_pkg::S_DIV: begin
        cmd.step   = 1'b1;
        state_next = sts.more ? dngr_pkg::S_MUL : dngr_pkg::S_EMIT;
      end
      dngr_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (sts.last) begin
            state_next = dngr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = dngr_pkg::S_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while glyphs pending");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && sts.last) |=> in_ready)
    else $error("not idle after last glyph");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == dngr_pkg::S_DIV && !sts.more) |=> out_valid)
    else $error("emission did not follow last divide step");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.step, cmd.advance}))
    else $error("conflicting datapath commands");

endmodule

FILE: tb/tb_decimal_number_glyph_renderer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_number_glyph_renderer
// Drives numbers and text box origins into the renderer and checks every
// glyph placement against an independent digit splitter. A short directed
// run covers zero, every digit, ten-digit numbers and the edges of the
// origin range. A random run follows with numbers of every length, random
// gaps on the input side and random back-pressure on the glyph side.
// ----------------------------------------------------------------------------
module tb_decimal_number_glyph_renderer;

  localparam int MAX_DIGITS = dngr_pkg::MAX_DIGITS_DEF;
  localparam int RANDOM_NUMBERS = 141;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [dngr_pkg::BITS_W-1:0] DIGIT_GLYPH [10] = '{
    20'hF999F, 20'hF2232, 20'hF168F, 20'hF8E8F, 20'h44F64,
    20'h7871F, 20'h6971E, 20'h1248F, 20'hF9F9F, 20'hF8F9F
  };

  typedef struct packed {
    logic [dngr_pkg::GLYPH_X_W-1:0] x;
    logic [dngr_pkg::COORD_W-1:0]   y;
    logic [dngr_pkg::BITS_W-1:0]    bits;
    logic [dngr_pkg::DIGIT_W-1:0]   digit;
    logic                           last;
  } glyph_t;

  class glyph_scoreboard;
    glyph_t expected_glyphs[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // split into digits, least significant first
    function void note_number(logic [dngr_pkg::NUMBER_W-1:0] num,
                              logic [dngr_pkg::COORD_W-1:0] ox,
                              logic [dngr_pkg::COORD_W-1:0] oy);
      int unsigned rest;
      int          digs[MAX_DIGITS];
      int          count;
      glyph_t      g;
      rest  = 32'(num);
      count = 0;
      if (rest == 0) begin
        digs[0] = 0;
        count   = 1;
      end else begin
        while (rest != 0 && count < MAX_DIGITS) begin
          digs[count] = rest % 10;
          rest        = rest / 10;
          count++;
        end
      end
      for (int k = 0; k < count; k++) begin
        g.x     = {1'b0, ox} + dngr_pkg::GLYPH_X_W'(dngr_pkg::GLYPH_PITCH * (count - 1 - k));
        g.y     = oy;
        g.bits  = DIGIT_GLYPH[digs[k]];
        g.digit = dngr_pkg::DIGIT_W'(digs[k]);
        g.last  = (k == count - 1);
        expected_glyphs.push_back(g);
      end
    endfunction

    function void check_glyph(glyph_t got);
      glyph_t exp_g;
      if (expected_glyphs.size() == 0) begin
        $display("%0t: unexpected glyph transaction, actual %h", $time, got);
        errors++;
        return;
      end
      exp_g = expected_glyphs.pop_front();
      if (got.x !== exp_g.x) begin
        $display("%0t: glyph_x mismatch, expected %0d actual %0d", $time, exp_g.x, got.x);
        errors++;
      end
      if (got.y !== exp_g.y) begin
        $display("%0t: glyph_y mismatch, expected %0d actual %0d", $time, exp_g.y, got.y);
        errors++;
      end
      if (got.bits !== exp_g.bits) begin
        $display("%0t: glyph_bits mismatch, expected %h actual %h", $time, exp_g.bits,
                 got.bits);
        errors++;
      end
      if (got.digit !== exp_g.digit) begin
        $display("%0t: digit_value mismatch, expected %0d actual %0d", $time, exp_g.digit,
                 got.digit);
        errors++;
      end
      if (got.last !== exp_g.last) begin
        $display("%0t: last_digit mismatch, expected %0d actual %0d", $time, exp_g.last,
                 got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_glyphs.size();
    endfunction

    function void report_leftovers();
      if (expected_glyphs.size() != 0) begin
        $display("%0t: %0d glyphs never arrived, next expected %h, actual none", $time,
                 expected_glyphs.size(), expected_glyphs[0]);
        errors += expected_glyphs.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b1;
  int   stall_left = 0;

  glyph_scoreboard sb = new();

  dngr_number_if number_ch();
  dngr_glyph_if  glyph_ch();

  decimal_number_glyph_renderer DUT (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .glyph  (glyph_ch)
  );

  always #5 clk = ~clk;

  // mostly short, sometimes long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (steady) begin
      glyph_ch.ready <= 1'b1;
      stall_left     <= 0;
    end else if (stall_left > 0) begin
      glyph_ch.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      glyph_ch.ready <= 1'b0;
      stall_left     <= idle_len();
    end else begin
      glyph_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (number_ch.valid && number_ch.ready)
        sb.note_number(number_ch.number_value, number_ch.origin_x, number_ch.origin_y);
      if (glyph_ch.valid && glyph_ch.ready)
        sb.check_glyph({glyph_ch.glyph_x, glyph_ch.glyph_y, glyph_ch.glyph_bits,
                        glyph_ch.digit_value, glyph_ch.last_digit});
    end
  end

  // called at a clock edge; returns at the edge the transaction completes
  task automatic send(logic [dngr_pkg::NUMBER_W-1:0] num,
                      logic [dngr_pkg::COORD_W-1:0] ox,
                      logic [dngr_pkg::COORD_W-1:0] oy);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      number_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    number_ch.valid        <= 1'b1;
    number_ch.number_value <= num;
    number_ch.origin_x     <= ox;
    number_ch.origin_y     <= oy;
    do @(posedge clk); while (!number_ch.ready);
  endtask

  task automatic drain();
    number_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    logic [dngr_pkg::NUMBER_W-1:0] num;
    logic [dngr_pkg::COORD_W-1:0]  ox;
    logic [dngr_pkg::COORD_W-1:0]  oy;
    longint unsigned               lo;
    longint unsigned               hi;
    int                            n;
    int                            pick;

    number_ch.valid        <= 1'b0;
    number_ch.number_value <= '0;
    number_ch.origin_x     <= '0;
    number_ch.origin_y     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send(31'd0, 10'd0, 10'd0);
    send(31'd0, 10'd1023, 10'd1023);
    send(31'd7, 10'd512, 10'd1);
    send(31'd10, 10'd3, 10'd700);
    send(31'd99, 10'd1023, 10'd0);
    send(31'd100, 10'd0, 10'd1023);
    send(31'd1234567890, 10'd1023, 10'd1023);
    send(31'd2147483647, 10'd1023, 10'd0);
    send(31'd1000000000, 10'd0, 10'd1023);
    send(31'd999999999, 10'd341, 10'd682);
    send(31'd1073741824, 10'd682, 10'd341);
    send(31'd1431655765, 10'd0, 10'd0);
    send(31'd45, 10'd1, 10'd2);
    send(31'd6, 10'd1000, 10'd500);
    send(31'd80, 10'd999, 10'd3);
    drain();

    steady <= 1'b0;
    send(31'd54321, 10'd1023, 10'd1023);
    send(31'd67890, 10'd0, 10'd0);
    send(31'd1, 10'd511, 10'd512);
    send(31'd2000000000, 10'd20, 10'd30);

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i == 60) begin
        drain();
        steady <= 1'b1;
      end
      if (i == 80) steady <= 1'b0;
      if (i == 110) drain();

      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        num = dngr_pkg::NUMBER_W'($urandom);
      end else if (pick < 25) begin
        num = '0;
      end else begin
        n  = $urandom_range(1, MAX_DIGITS);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = (n == MAX_DIGITS) ? 64'd2147483647 : lo * 10 - 1;
        num = dngr_pkg::NUMBER_W'($urandom_range(int'(hi), int'(lo)));
      end

      pick = $urandom_range(0, 9);
      ox = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 : 10'($urandom);
      pick = $urandom_range(0, 9);
      oy = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 : 10'($urandom);

      send(num, ox, oy);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.report_leftovers();
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("timeout waiting for glyph transactions");
    $display("status: fail");
    $finish;
  end

endmodule

FILE: decimal_number_glyph_renderer.f
hdl/dngr_pkg.sv
hdl/dngr_number_if.sv
hdl/dngr_glyph_if.sv
hdl/dngr_dp.sv
hdl/dngr_ctrl.sv
hdl/decimal_number_glyph_renderer.sv
tb/tb_decimal_number_glyph_renderer.sv
